FILE: hdl/rhc_pkg.sv
// Shared types and constants for the 8-bit RGB/HSV converter.
// No dependencies; imported by the top level, front, divider cell and back modules.
`default_nettype none
package rhc_pkg;

  localparam int DivSteps = 8;

  localparam logic [7:0] HueSector = 8'd43;
  localparam logic [7:0] BaseRed   = 8'd0;
  localparam logic [7:0] BaseGreen = 8'd85;
  localparam logic [7:0] BaseBlue  = 8'd171;

  localparam logic FuncToHsv = 1'b0;
  localparam logic FuncToRgb = 1'b1;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic       func;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
  } out_beat_t;

  // Divider lane: partial remainder, numerator bits / quotient bits, divisor.
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] nq;
    logic [7:0] div;
  } lane_t;

  // Side data carried alongside the dividers.
  typedef struct packed {
    logic       func;
    logic       grey;
    logic       neg;
    logic [7:0] base;
    sector_t    sector;
    logic [7:0] offs;
    logic [7:0] sat;
    logic [7:0] val;
  } side_t;

  typedef struct packed {
    logic  valid;
    side_t side;
    lane_t sat_lane;
    lane_t hue_lane;
  } cell_t;

endpackage
`default_nettype wire

FILE: hdl/rgb_hsv_converter_8bit.sv
// Top level of the 8-bit RGB/HSV converter: front stage, divider cell row, back stages.
// Depends on rhc_pkg, rhc_front, rhc_div_cell, rhc_back.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall   | rhc_pkg::in_beat_t
//   out     | output    | out_valid / out_stall | rhc_pkg::out_beat_t
//
// One beat per cycle unless a result waits under out_stall. Stages: front register, 8 divider
// cells (one quotient bit per cell), product stage, output register.
// Synchronous active-low reset clears all valid bits.
// The whole pipe holds while a result waits under out_stall; in_stall follows.
`default_nettype none
module rgb_hsv_converter_8bit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rhc_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rhc_pkg::out_beat_t      out_data
);
  import rhc_pkg::*;

  logic  ena;
  cell_t chain [DivSteps+1];

  assign ena      = !(out_valid && out_stall);
  assign in_stall = !ena;

  rhc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .ena     (ena),
    .in_valid(in_valid),
    .in_data (in_data),
    .cell_r  (chain[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ena    (ena),
      .cell_in(chain[i]),
      .cell_r (chain[i+1])
    );
  end

  rhc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ena      (ena),
    .cell_in  (chain[DivSteps]),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

FILE: hdl/rhc_front.sv
// Input stage: max/min, hue base and sign, sector split, divider setup.
// Depends on rhc_pkg.
`default_nettype none
module rhc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            ena,
  input  wire logic            in_valid,
  input  wire rhc_pkg::in_beat_t in_data,
  output rhc_pkg::cell_t       cell_r
);
  import rhc_pkg::*;

  cell_t       cell_nxt;
  logic [7:0]  r, g, b, mx, mn, delta, pa, pb, absd, h, hbase, hoff;
  logic [15:0] num_sat, num_hue;
  logic        neg;
  logic [7:0]  base;
  sector_t     sector;

  always_comb begin
    r = in_data.chan0;
    g = in_data.chan1;
    b = in_data.chan2;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    if (mx == r) begin
      base = BaseRed;
      pa = g;
      pb = b;
    end else if (mx == g) begin
      base = BaseGreen;
      pa = b;
      pb = r;
    end else begin
      base = BaseBlue;
      pa = r;
      pb = g;
    end
    neg  = pa < pb;
    absd = neg ? (pb - pa) : (pa - pb);
    num_sat = {8'd0, delta} * 16'd255;
    num_hue = {8'd0, absd} * {8'd0, HueSector};

    h = in_data.chan0;
    if (h >= 8'(5 * HueSector)) begin
      sector = SECTOR_5;
      hbase  = 8'(5 * HueSector);
    end else if (h >= 8'(4 * HueSector)) begin
      sector = SECTOR_4;
      hbase  = 8'(4 * HueSector);
    end else if (h >= 8'(3 * HueSector)) begin
      sector = SECTOR_3;
      hbase  = 8'(3 * HueSector);
    end else if (h >= 8'(2 * HueSector)) begin
      sector = SECTOR_2;
      hbase  = 8'(2 * HueSector);
    end else if (h >= HueSector) begin
      sector = SECTOR_1;
      hbase  = HueSector;
    end else begin
      sector = SECTOR_0;
      hbase  = 8'd0;
    end
    hoff = h - hbase;

    cell_nxt.valid       = in_valid;
    cell_nxt.side.func   = in_data.func;
    cell_nxt.side.neg    = neg;
    cell_nxt.side.base   = base;
    cell_nxt.side.sector = sector;
    cell_nxt.side.offs   = (hoff << 2) + (hoff << 1);
    cell_nxt.side.sat    = in_data.chan1;
    if (in_data.func == FuncToRgb) begin
      cell_nxt.side.grey = in_data.chan1 == 8'd0;
      cell_nxt.side.val  = in_data.chan2;
    end else begin
      cell_nxt.side.grey = mx == mn;
      cell_nxt.side.val  = mx;
    end
    cell_nxt.sat_lane.rem = num_sat[15:8];
    cell_nxt.sat_lane.nq  = num_sat[7:0];
    cell_nxt.sat_lane.div = mx;
    cell_nxt.hue_lane.rem = num_hue[15:8];
    cell_nxt.hue_lane.nq  = num_hue[7:0];
    cell_nxt.hue_lane.div = delta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (ena) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (ena) begin
      cell_r.side     <= cell_nxt.side;
      cell_r.sat_lane <= cell_nxt.sat_lane;
      cell_r.hue_lane <= cell_nxt.hue_lane;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rhc_div_cell.sv
// One restoring-division cell: one quotient bit for each lane per beat.
// Depends on rhc_pkg.
`default_nettype none
module rhc_div_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ena,
  input  wire rhc_pkg::cell_t cell_in,
  output rhc_pkg::cell_t     cell_r
);
  import rhc_pkg::*;

  function automatic lane_t lane_step(lane_t l);
    lane_t      o;
    logic [8:0] r9, d9;
    logic       ge;
    r9 = {l.rem, l.nq[7]};
    d9 = {1'b0, l.div};
    ge = r9 >= d9;
    o.rem = ge ? 8'(r9 - d9) : r9[7:0];
    o.nq  = {l.nq[6:0], ge};
    o.div = l.div;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (ena) begin
      cell_r.valid <= cell_in.valid;
    end
    if (ena) begin
      cell_r.side     <= cell_in.side;
      cell_r.sat_lane <= lane_step(cell_in.sat_lane);
      cell_r.hue_lane <= lane_step(cell_in.hue_lane);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rhc_back.sv
// Output stages: hue/saturation assembly, p/q/t products, sector mux.
// Depends on rhc_pkg.
`default_nettype none
module rhc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             ena,
  input  wire rhc_pkg::cell_t   cell_in,
  output logic                  out_valid,
  output rhc_pkg::out_beat_t    out_data
);
  import rhc_pkg::*;

  typedef struct packed {
    logic       valid;
    logic       func;
    logic       grey;
    sector_t    sector;
    logic [7:0] val;
    logic [7:0] p;
    logic [7:0] m1;
    logic [7:0] m2;
    logic [7:0] hue;
    logic [7:0] sat;
  } mid_t;

  mid_t       mid_r, mid_nxt;
  logic       vld_r;
  out_beat_t  res_r, res_nxt;
  logic [7:0] qh, qs;
  logic [15:0] pr_m1, pr_m2, pr_p, pr_q, pr_t;
  logic [7:0]  q, t;

  always_comb begin
    qh = cell_in.hue_lane.nq;
    qs = cell_in.sat_lane.nq;
    pr_m1 = {8'd0, cell_in.side.sat} * {8'd0, cell_in.side.offs};
    pr_m2 = {8'd0, cell_in.side.sat} * {8'd0, 8'd255 - cell_in.side.offs};
    pr_p  = {8'd0, cell_in.side.val} * {8'd0, 8'd255 - cell_in.side.sat};
    mid_nxt.valid  = cell_in.valid;
    mid_nxt.func   = cell_in.side.func;
    mid_nxt.grey   = cell_in.side.grey;
    mid_nxt.sector = cell_in.side.sector;
    mid_nxt.val    = cell_in.side.val;
    mid_nxt.p      = pr_p[15:8];
    mid_nxt.m1     = pr_m1[15:8];
    mid_nxt.m2     = pr_m2[15:8];
    if (cell_in.side.grey) begin
      mid_nxt.hue = 8'd0;
      mid_nxt.sat = 8'd0;
    end else begin
      mid_nxt.hue = cell_in.side.neg ? (cell_in.side.base - qh) : (cell_in.side.base + qh);
      mid_nxt.sat = qs;
    end
  end

  always_comb begin
    pr_q = {8'd0, mid_r.val} * {8'd0, 8'd255 - mid_r.m1};
    pr_t = {8'd0, mid_r.val} * {8'd0, 8'd255 - mid_r.m2};
    q = pr_q[15:8];
    t = pr_t[15:8];
    if (mid_r.func == FuncToHsv) begin
      res_nxt = '{out0: mid_r.hue, out1: mid_r.sat, out2: mid_r.val};
    end else if (mid_r.grey) begin
      res_nxt = '{out0: mid_r.val, out1: mid_r.val, out2: mid_r.val};
    end else begin
      case (mid_r.sector)
        SECTOR_0: res_nxt = '{out0: mid_r.val, out1: t,         out2: mid_r.p};
        SECTOR_1: res_nxt = '{out0: q,         out1: mid_r.val, out2: mid_r.p};
        SECTOR_2: res_nxt = '{out0: mid_r.p,   out1: mid_r.val, out2: t};
        SECTOR_3: res_nxt = '{out0: mid_r.p,   out1: q,         out2: mid_r.val};
        SECTOR_4: res_nxt = '{out0: t,         out1: mid_r.p,   out2: mid_r.val};
        default:  res_nxt = '{out0: mid_r.val, out1: mid_r.p,   out2: q};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
      vld_r       <= 1'b0;
    end else if (ena) begin
      mid_r.valid <= mid_nxt.valid;
      vld_r       <= mid_r.valid;
    end
    if (ena) begin
      mid_r.func   <= mid_nxt.func;
      mid_r.grey   <= mid_nxt.grey;
      mid_r.sector <= mid_nxt.sector;
      mid_r.val    <= mid_nxt.val;
      mid_r.p      <= mid_nxt.p;
      mid_r.m1     <= mid_nxt.m1;
      mid_r.m2     <= mid_nxt.m2;
      mid_r.hue    <= mid_nxt.hue;
      mid_r.sat    <= mid_nxt.sat;
      res_r        <= res_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = res_r;

endmodule
`default_nettype wire

FILE: hdl/rhc_checker.sv
// Port-level checks for the converter, bound to the top level.
// Depends on rhc_pkg and rgb_hsv_converter_8bit.
`default_nettype none
module rhc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire rhc_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed under stall");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rgb_hsv_converter_8bit rhc_checker u_rhc_checker (.*);
`default_nettype wire
